>>> hw/rtl/scc_pkg.sv
// shared constants, types and the set-1 key table for the scancode text console
`default_nettype none
package scc_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);

  localparam logic [7:0]  CHAR_BLANK     = 8'h20;
  localparam logic [7:0]  CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0]  ATTR_RESET     = 8'h07;
  localparam logic [15:0] CELL_RESET     = {ATTR_RESET, CHAR_BLANK};

  typedef enum logic [1:0] {
    OP_SCANCODE = 2'd0,
    OP_PUT      = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DONE,
    ST_SWEEP
  } state_t;

  // cell write and new cursor produced by one character put
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } put_res_t;

  // make codes of scancode set 1 to ascii, zero where nothing is printed
  function automatic logic [7:0] key_ascii(input logic [6:0] code);
    logic [7:0] a;
    a = 8'h00;
    case (code)
      7'h01: a = 8'h1B;
      7'h02: a = 8'h31;
      7'h03: a = 8'h32;
      7'h04: a = 8'h33;
      7'h05: a = 8'h34;
      7'h06: a = 8'h35;
      7'h07: a = 8'h36;
      7'h08: a = 8'h37;
      7'h09: a = 8'h38;
      7'h0A: a = 8'h39;
      7'h0B: a = 8'h30;
      7'h0C: a = 8'h2D;
      7'h0D: a = 8'h3D;
      7'h0E: a = 8'h08;
      7'h0F: a = 8'h09;
      7'h10: a = 8'h71;
      7'h11: a = 8'h77;
      7'h12: a = 8'h65;
      7'h13: a = 8'h72;
      7'h14: a = 8'h74;
      7'h15: a = 8'h79;
      7'h16: a = 8'h75;
      7'h17: a = 8'h69;
      7'h18: a = 8'h6F;
      7'h19: a = 8'h70;
      7'h1A: a = 8'h5B;
      7'h1B: a = 8'h5D;
      7'h1C: a = 8'h0A;
      7'h1E: a = 8'h61;
      7'h1F: a = 8'h73;
      7'h20: a = 8'h64;
      7'h21: a = 8'h66;
      7'h22: a = 8'h67;
      7'h23: a = 8'h68;
      7'h24: a = 8'h6A;
      7'h25: a = 8'h6B;
      7'h26: a = 8'h6C;
      7'h27: a = 8'h3B;
      7'h28: a = 8'h27;
      7'h29: a = 8'h60;
      7'h2B: a = 8'h5C;
      7'h2C: a = 8'h7A;
      7'h2D: a = 8'h78;
      7'h2E: a = 8'h63;
      7'h2F: a = 8'h76;
      7'h30: a = 8'h62;
      7'h31: a = 8'h6E;
      7'h32: a = 8'h6D;
      7'h33: a = 8'h2C;
      7'h34: a = 8'h2E;
      7'h35: a = 8'h2F;
      7'h37: a = 8'h2A;
      7'h39: a = 8'h20;
      default: a = 8'h00;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/scc_cell_ram.sv
// cell store: one write port, one read port with registered read data
`default_nettype none
module scc_cell_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [scc_pkg::ADDR_W-1:0] waddr,
  input  wire logic [15:0]               wdata,
  input  wire logic                      re,
  input  wire logic [scc_pkg::ADDR_W-1:0] raddr,
  output logic      [15:0]               rdata
);

  logic [15:0] mem [scc_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/scc_put_unit.sv
// cursor update and cell write for one character put
`default_nettype none
module scc_put_unit (
  input  wire logic [scc_pkg::ROW_W-1:0] row,
  input  wire logic [scc_pkg::COL_W-1:0] col,
  input  wire logic [7:0]                ch,
  input  wire logic [7:0]                attr,
  output scc_pkg::put_res_t              res
);

  logic [scc_pkg::ADDR_W-1:0] addr_cur;
  logic [scc_pkg::ROW_W-1:0]  row_down;
  logic                       col_last;

  assign addr_cur = scc_pkg::ADDR_W'(row) * scc_pkg::ADDR_W'(scc_pkg::COLUMNS)
                    + scc_pkg::ADDR_W'(col);
  // bottom row stays put, no scroll
  assign row_down = (row == scc_pkg::ROW_W'(scc_pkg::ROWS - 1)) ? row : row + 1'b1;
  assign col_last = (col == scc_pkg::COL_W'(scc_pkg::COLUMNS - 1));

  always_comb begin
    res.we   = 1'b0;
    res.addr = addr_cur;
    res.data = {attr, ch};
    res.row  = row;
    res.col  = col;
    case (ch)
      scc_pkg::CHAR_NEWLINE: begin
        res.row = row_down;
        res.col = '0;
      end
      scc_pkg::CHAR_BACKSPACE: begin
        if (col != '0) begin
          res.we   = 1'b1;
          res.addr = addr_cur - 1'b1;
          res.data = {attr, scc_pkg::CHAR_BLANK};
          res.col  = col - 1'b1;
        end
      end
      default: begin
        res.we = 1'b1;
        if (col_last) begin
          res.col = '0;
          res.row = row_down;
        end else begin
          res.col = col + 1'b1;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/scancode_text_console_unit.sv
// top level of the scancode text console: control, cursor and output register
`default_nettype none
// A transaction goes from acceptance to the done state, which loads the result register: a put or
// scancode writes its cell, if any, in the accept cycle, a read gets its data from the registered
// read port of the cell memory. A clear-screen transaction sweeps the whole store, one cell per
// cycle, before it reaches the done state. After reset the same sweep fills the store with blank
// cells of attribute 7; no input is accepted until that fill is done, while cfg writes are taken
// at once. The attribute register may be written only while no transaction is in progress. One
// finished result can wait in the output register while the next transaction is accepted and
// worked on.
module scancode_text_console_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_scancode,
  input  wire logic [7:0]  in_character,
  input  wire logic [10:0] in_cell_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] out_cell_value,
  output logic      [4:0]  out_cursor_row,
  output logic      [6:0]  out_cursor_column,
  output logic             out_char_taken
);

  scc_pkg::state_t state_r, state_nxt;
  logic [scc_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [scc_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [7:0]                 attr_r, attr_nxt;
  logic [scc_pkg::ADDR_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic                       sweep_init_r, sweep_init_nxt;
  logic [15:0]                sweep_cell_r, sweep_cell_nxt;
  logic                       rd_sel_r, rd_sel_nxt;
  logic                       taken_r, taken_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [15:0]                out_value_r, out_value_nxt;
  logic [4:0]                 out_row_r, out_row_nxt;
  logic [6:0]                 out_col_r, out_col_nxt;
  logic                       out_taken_r, out_taken_nxt;

  logic                       accept;
  logic                       put_en;
  logic [7:0]                 put_ch;
  logic [7:0]                 key_ch;
  logic                       idx_ok;
  scc_pkg::put_res_t          put_res;
  logic                       ram_we;
  logic [scc_pkg::ADDR_W-1:0] ram_waddr;
  logic [15:0]                ram_wdata;
  logic                       ram_re;
  logic [15:0]                ram_rdata;

  assign in_ready = (state_r == scc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign key_ch   = scc_pkg::key_ascii(in_scancode[6:0]);
  assign idx_ok   = (32'(in_cell_index) < scc_pkg::CELL_COUNT);

  scc_put_unit u_put (
    .row  (row_r),
    .col  (col_r),
    .ch   (put_ch),
    .attr (attr_r),
    .res  (put_res)
  );

  scc_cell_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scc_pkg::ADDR_W'(in_cell_index)),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    attr_nxt       = cfg_wr_en ? cfg_wr_data : attr_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_init_nxt = sweep_init_r;
    sweep_cell_nxt = sweep_cell_r;
    rd_sel_nxt     = rd_sel_r;
    taken_nxt      = taken_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_taken_nxt  = out_taken_r;
    put_en         = 1'b0;
    put_ch         = in_character;
    ram_we         = 1'b0;
    ram_waddr      = put_res.addr;
    ram_wdata      = put_res.data;
    ram_re         = 1'b0;

    case (state_r)
      scc_pkg::ST_IDLE: begin
        if (accept) begin
          rd_sel_nxt = 1'b0;
          taken_nxt  = 1'b0;
          state_nxt  = scc_pkg::ST_DONE;
          case (scc_pkg::op_t'(in_operation))
            scc_pkg::OP_SCANCODE: begin
              // release codes and unmapped keys put nothing
              put_ch = key_ch;
              put_en = !in_scancode[7] && (key_ch != 8'h00);
            end
            scc_pkg::OP_PUT: begin
              put_en = 1'b1;
            end
            scc_pkg::OP_CLEAR: begin
              row_nxt        = '0;
              col_nxt        = '0;
              sweep_addr_nxt = '0;
              sweep_init_nxt = 1'b0;
              sweep_cell_nxt = {attr_r, scc_pkg::CHAR_BLANK};
              state_nxt      = scc_pkg::ST_SWEEP;
            end
            scc_pkg::OP_READ: begin
              ram_re     = idx_ok;
              rd_sel_nxt = idx_ok;
            end
            default: begin
              state_nxt = scc_pkg::ST_DONE;
            end
          endcase
          if (put_en) begin
            ram_we    = put_res.we;
            row_nxt   = put_res.row;
            col_nxt   = put_res.col;
            taken_nxt = 1'b1;
          end
        end
      end
      scc_pkg::ST_SWEEP: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_addr_r;
        ram_wdata      = sweep_cell_r;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_addr_r == scc_pkg::ADDR_W'(scc_pkg::CELL_COUNT - 1)) begin
          // the power-up fill has no transaction behind it
          state_nxt = sweep_init_r ? scc_pkg::ST_IDLE : scc_pkg::ST_DONE;
        end
      end
      scc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_sel_r ? ram_rdata : 16'h0000;
          out_row_nxt   = 5'(row_r);
          out_col_nxt   = 7'(col_r);
          out_taken_nxt = taken_r;
          state_nxt     = scc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= scc_pkg::ST_SWEEP;
      row_r        <= '0;
      col_r        <= '0;
      attr_r       <= scc_pkg::ATTR_RESET;
      sweep_addr_r <= '0;
      sweep_init_r <= 1'b1;
      sweep_cell_r <= scc_pkg::CELL_RESET;
      rd_sel_r     <= 1'b0;
      taken_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      attr_r       <= attr_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_init_r <= sweep_init_nxt;
      sweep_cell_r <= sweep_cell_nxt;
      rd_sel_r     <= rd_sel_nxt;
      taken_r      <= taken_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_taken_r <= out_taken_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_cell_value    = out_value_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;
  assign out_char_taken    = out_taken_r;

  // cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < scc_pkg::ROWS) && (32'(col_r) < scc_pkg::COLUMNS))
    else $error("cursor outside the screen");

  // the store is written only by a sweep or by an accepted transaction
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == scc_pkg::ST_SWEEP) || accept)
    else $error("cell write with no transaction behind it");

  // clear homes the cursor and starts a sweep
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_operation == scc_pkg::OP_CLEAR) |=>
      (state_r == scc_pkg::ST_SWEEP) && (row_r == '0) && (col_r == '0))
    else $error("clear did not home the cursor");

  // a read goes straight to result, a read result never claims a character
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_operation == scc_pkg::OP_READ) |=>
      (state_r == scc_pkg::ST_DONE) && !taken_r)
    else $error("read transaction mishandled");

  // a loaded result comes from the done state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == scc_pkg::ST_DONE))
    else $error("result loaded outside the done state");

endmodule
`default_nettype wire

>>> sim/testbench.sv
// testbench for the scancode text console: directed and random transactions against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // set-1 make codes to ascii, entry 0 in the top byte
  localparam int KEY_COUNT = 58;
  localparam logic [KEY_COUNT*8-1:0] KEY_MAP = {
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
    8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
    8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  typedef struct packed {
    logic [15:0] value;
    logic [4:0]  row;
    logic [6:0]  column;
    logic        taken;
  } console_status_t;

  class screen_predictor;
    logic [15:0] cells [scc_pkg::CELL_COUNT];
    int row;
    int col;
    logic [7:0] attr;
    console_status_t expected_status [$];
    int mismatches;

    function new();
      attr = scc_pkg::ATTR_RESET;
      row = 0;
      col = 0;
      mismatches = 0;
      foreach (cells[i]) cells[i] = scc_pkg::CELL_RESET;
    endfunction

    function void put_char(logic [7:0] ch);
      if (ch == scc_pkg::CHAR_NEWLINE) begin
        col = 0;
        if (row < scc_pkg::ROWS - 1) row++;
      end else if (ch == scc_pkg::CHAR_BACKSPACE) begin
        if (col > 0) begin
          col--;
          cells[row * scc_pkg::COLUMNS + col] = {attr, scc_pkg::CHAR_BLANK};
        end
      end else begin
        cells[row * scc_pkg::COLUMNS + col] = {attr, ch};
        if (col == scc_pkg::COLUMNS - 1) begin
          col = 0;
          if (row < scc_pkg::ROWS - 1) row++;
        end else begin
          col++;
        end
      end
    endfunction

    function void note_transaction(scc_pkg::op_t op, logic [7:0] code, logic [7:0] ch,
                                   logic [10:0] idx);
      console_status_t s;
      logic [7:0] key;
      int k;
      s = '0;
      case (op)
        scc_pkg::OP_SCANCODE: begin
          // release codes fall outside the map
          k = int'(code);
          key = (k < KEY_COUNT) ? KEY_MAP[(KEY_COUNT - 1 - k) * 8 +: 8] : 8'h00;
          if (key != 8'h00) begin
            put_char(key);
            s.taken = 1'b1;
          end
        end
        scc_pkg::OP_PUT: begin
          put_char(ch);
          s.taken = 1'b1;
        end
        scc_pkg::OP_CLEAR: begin
          foreach (cells[i]) cells[i] = {attr, scc_pkg::CHAR_BLANK};
          row = 0;
          col = 0;
        end
        default: begin
          if (idx < scc_pkg::CELL_COUNT) s.value = cells[idx];
        end
      endcase
      s.row = 5'(row);
      s.column = 7'(col);
      expected_status.push_back(s);
    endfunction

    function void check_result(logic [15:0] value, logic [4:0] r, logic [6:0] c, logic t);
      console_status_t want;
      if (expected_status.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      if (value !== want.value) begin
        $error("cell_value: expected %h, got %h", want.value, value);
        mismatches++;
      end
      if (r !== want.row) begin
        $error("cursor_row: expected %0d, got %0d", want.row, r);
        mismatches++;
      end
      if (c !== want.column) begin
        $error("cursor_column: expected %0d, got %0d", want.column, c);
        mismatches++;
      end
      if (t !== want.taken) begin
        $error("char_taken: expected %0d, got %0d", want.taken, t);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = scc_pkg::OP_SCANCODE;
  logic [7:0]  in_scancode = 8'h00;
  logic [7:0]  in_character = 8'h00;
  logic [10:0] in_cell_index = 11'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_cell_value;
  logic [4:0]  out_cursor_row;
  logic [6:0]  out_cursor_column;
  logic        out_char_taken;

  screen_predictor console_model;
  int idle_odds = 5;
  int items_sent = 0;
  bit hold_request = 1'b0;

  scancode_text_console_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_scancode       (in_scancode),
    .in_character      (in_character),
    .in_cell_index     (in_cell_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_value    (out_cell_value),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column),
    .out_char_taken    (out_char_taken)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        console_model.check_result(out_cell_value, out_cursor_row, out_cursor_column,
                                   out_char_taken);
      if (hold_request) begin
        stall_left = 80;
        hold_request = 1'b0;
      end else if (stall_left == 0 && idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        stall_left = int'($urandom_range(1, 9));
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid stays high between back-to-back transactions; callers lower it in the same step
  task automatic send_item(scc_pkg::op_t op, logic [7:0] code, logic [7:0] ch,
                           logic [10:0] idx);
    if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_scancode <= code;
    in_character <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    console_model.note_transaction(op, code, ch, idx);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (console_model.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    console_model.attr = value;
  endtask

  task automatic run_random(int count, bit with_hold);
    int start, pick, base;
    bit held;
    logic [7:0] ch;
    logic [10:0] idx;
    start = items_sent;
    held = 1'b0;
    while (items_sent - start < count) begin
      if (with_hold && !held && items_sent - start >= count / 2) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // typing: mostly make codes, some releases, direct puts and reads near the cursor
        repeat ($urandom_range(5, 30)) begin
          pick = $urandom_range(0, 99);
          ch = 8'($urandom);
          idx = 11'($urandom_range(0, scc_pkg::CELL_COUNT - 1));
          if (pick < 50) begin
            send_item(scc_pkg::OP_SCANCODE, 8'($urandom_range(0, 'h3A)), ch, idx);
          end else if (pick < 60) begin
            send_item(scc_pkg::OP_SCANCODE, 8'($urandom_range('h80, 'hFF)), ch, idx);
          end else if (pick < 78) begin
            send_item(scc_pkg::OP_PUT, 8'($urandom), ch, idx);
          end else if (pick < 95) begin
            base = console_model.row * scc_pkg::COLUMNS + console_model.col
                   - int'($urandom_range(0, 4));
            if (base < 0) base = 0;
            send_item(scc_pkg::OP_READ, 8'($urandom), ch, 11'(base));
          end else begin
            send_item(scc_pkg::OP_PUT, 8'($urandom), scc_pkg::CHAR_NEWLINE, idx);
          end
        end
      end else if (pick < 55) begin
        // long line so the cursor wraps
        repeat (85) begin
          do ch = 8'($urandom);
          while (ch == scc_pkg::CHAR_NEWLINE || ch == scc_pkg::CHAR_BACKSPACE);
          send_item(scc_pkg::OP_PUT, 8'($urandom), ch, 11'($urandom));
        end
      end else if (pick < 65) begin
        repeat ($urandom_range(10, 30)) begin
          if ($urandom_range(0, 1))
            send_item(scc_pkg::OP_PUT, 8'($urandom), scc_pkg::CHAR_NEWLINE, 11'($urandom));
          else
            send_item(scc_pkg::OP_SCANCODE, 8'h1C, 8'($urandom), 11'($urandom));
        end
      end else if (pick < 73) begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 1))
            send_item(scc_pkg::OP_PUT, 8'($urandom), scc_pkg::CHAR_BACKSPACE, 11'($urandom));
          else
            send_item(scc_pkg::OP_SCANCODE, 8'h0E, 8'($urandom), 11'($urandom));
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(10, 20)) begin
          if ($urandom_range(0, 9) == 0)
            idx = 11'($urandom_range(scc_pkg::CELL_COUNT, 2047));
          else
            idx = 11'($urandom_range(0, scc_pkg::CELL_COUNT - 1));
          send_item(scc_pkg::OP_READ, 8'($urandom), 8'($urandom), idx);
        end
      end else if (pick < 88) begin
        send_item(scc_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
      end else begin
        repeat ($urandom_range(5, 15))
          send_item(scc_pkg::op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                    11'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    console_model = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // the store is swept blank after reset before any transaction is taken
    while (in_ready !== 1'b1) @(posedge clk);
    write_attribute(8'h1F);

    send_item(scc_pkg::OP_READ, 8'h00, 8'h00, 11'd0);
    send_item(scc_pkg::OP_READ, 8'h00, 8'h00, 11'(scc_pkg::CELL_COUNT - 1));
    send_item(scc_pkg::OP_READ, 8'h00, 8'h00, 11'(scc_pkg::CELL_COUNT));
    send_item(scc_pkg::OP_READ, 8'hFF, 8'hFF, 11'h7FF);
    send_item(scc_pkg::OP_PUT, 8'h00, scc_pkg::CHAR_BACKSPACE, 11'd0);
    send_item(scc_pkg::OP_PUT, 8'h00, 8'h00, 11'd0);
    send_item(scc_pkg::OP_PUT, 8'h00, 8'hFF, 11'd0);
    send_item(scc_pkg::OP_PUT, 8'h00, 8'h41, 11'd0);
    send_item(scc_pkg::OP_PUT, 8'h00, scc_pkg::CHAR_BACKSPACE, 11'd0);
    send_item(scc_pkg::OP_PUT, 8'h00, scc_pkg::CHAR_NEWLINE, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'h1E, 8'h00, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'h9E, 8'h00, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'h00, 8'h00, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'h1D, 8'h00, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'h7F, 8'h00, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'hFF, 8'h00, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'h39, 8'h00, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'h0E, 8'h00, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'h1C, 8'h00, 11'd0);
    send_item(scc_pkg::OP_SCANCODE, 8'h0E, 8'h00, 11'd0);
    send_item(scc_pkg::OP_READ, 8'h00, 8'h00, 11'd0);
    send_item(scc_pkg::OP_READ, 8'h00, 8'h00, 11'd1);
    send_item(scc_pkg::OP_READ, 8'h00, 8'h00, 11'(scc_pkg::COLUMNS));
    send_item(scc_pkg::OP_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
    send_item(scc_pkg::OP_READ, 8'h00, 8'h00, 11'd0);
    drain_results();

    write_attribute(8'hFF);
    idle_odds = 4;
    run_random(260, 1'b1);
    drain_results();

    write_attribute(8'h00);
    idle_odds = 10;
    run_random(260, 1'b0);
    drain_results();

    write_attribute(8'($urandom));
    idle_odds = 0;
    run_random(260, 1'b0);
    drain_results();
    repeat (20) @(posedge clk);

    if (console_model.mismatches == 0 && console_model.expected_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/scc_pkg.sv
hw/rtl/scc_cell_ram.sv
hw/rtl/scc_put_unit.sv
hw/rtl/scancode_text_console_unit.sv
sim/testbench.sv
